/* rtl/cepstral_delta_feature_streams_core_macros.svh */
// Assertion macros used by the checker file of the delta feature block.
`ifndef CEPSTRAL_DELTA_FEATURE_STREAMS_CORE_MACROS_SVH
`define CEPSTRAL_DELTA_FEATURE_STREAMS_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDFS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CDFS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cdfs_pkg.sv */
// Shared constants and stream codes of the cepstral delta feature block.
package cdfs_pkg;

	localparam int CEP_LEN_DEF      = 12;
	localparam int SHORT_WIN_DEF    = 2;
	localparam int LONG_WIN_DEF     = 4;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int IDX_W_DEF        = $clog2(CEP_LEN_DEF + 1);

	localparam int SID_W = 2;
	localparam int EI_W  = 5;
	localparam int FV_W  = 18;

	localparam logic [SID_W-1:0] STREAM_CEP   = 2'd0;
	localparam logic [SID_W-1:0] STREAM_DELTA = 2'd1;
	localparam logic [SID_W-1:0] STREAM_PWR   = 2'd2;
	localparam logic [SID_W-1:0] STREAM_DD    = 2'd3;

endpackage

/* rtl/cdfs_in_if.sv */
// Input channel: one cepstral coefficient per item.
interface cdfs_in_if
	import cdfs_pkg::*;
	#(
	parameter int IDX_W = IDX_W_DEF,
	parameter int SMP_W = SAMPLE_WIDTH_DEF
	);

	logic                    valid;
	logic                    ready;
	logic [IDX_W-1:0]        coef_index;
	logic signed [SMP_W-1:0] coef_value;

	modport source (output valid, coef_index, coef_value, input ready);
	modport sink   (input valid, coef_index, coef_value, output ready);

endinterface

/* rtl/cdfs_out_if.sv */
// Output channel: one feature value per item.
interface cdfs_out_if
	import cdfs_pkg::*;
	;

	logic                   valid;
	logic                   ready;
	logic [SID_W-1:0]       stream_id;
	logic [EI_W-1:0]        element_index;
	logic signed [FV_W-1:0] feature_value;
	logic                   last_of_frame;

	modport source (output valid, stream_id, element_index, feature_value, last_of_frame,
		input ready);
	modport sink   (input valid, stream_id, element_index, feature_value, last_of_frame,
		output ready);

endinterface

/* rtl/cdfs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module cdfs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 117
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/cepstral_delta_feature_streams_core.sv */
// Cepstral delta feature block: frame history RAM and result sequencer.
//
// coef carries one coefficient per item, c0 first and c[CEP_LEN] last; each
// coefficient is written straight into the frame history RAM. The item with
// index CEP_LEN closes the frame. From the close that brings the frames held
// to 2*LONG_WIN+1 on, every close starts the sequencer, which emits
// 4*CEP_LEN+3 items on feat for the frame LONG_WIN frames back (51 at the
// defaults). Every value is a signed sum of up to four history entries, read
// one per cycle through the single read port of the RAM while the receiver
// does not stall; coef is not ready until the read sweep of the frame is
// done. On its way to feat, each result passes the RAM read register and the
// output register. Indices above CEP_LEN are accepted and dropped. When the
// receiver stalls, the whole read pipeline freezes, the RAM output holds,
// and the pending result stays on feat. Reset clears the frame count and
// the slot pointer; the history RAM itself is not cleared.
module cepstral_delta_feature_streams_core
	import cdfs_pkg::*;
	#(
	parameter int CEP_LEN      = CEP_LEN_DEF,
	parameter int SHORT_WIN    = SHORT_WIN_DEF,
	parameter int LONG_WIN     = LONG_WIN_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
	) (
	input  logic         clk,
	input  logic         arst_n,
	cdfs_in_if.sink      coef,
	cdfs_out_if.source   feat
);

	localparam int HD     = 2 * LONG_WIN + 1;
	localparam int FL     = CEP_LEN + 1;
	localparam int DEPTH  = HD * FL;
	localparam int AW     = $clog2(DEPTH);
	localparam int SLOT_W = $clog2(HD);
	localparam int IDX_W  = $clog2(CEP_LEN + 1);
	localparam int HELD_W = $clog2(HD + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_CEP, ST_DSH, ST_DLG, ST_PW0, ST_PW1, ST_PW2, ST_DD
	} state_t;

	typedef enum logic [1:0] {K_PLAIN, K_DELTA, K_DD} kind_t;

	state_t              state_q;
	logic [IDX_W-1:0]    i_q;
	logic [1:0]          t_q;
	logic [SLOT_W-1:0]   newest_slot_q;
	logic [HELD_W-1:0]   frames_held_q;

	logic                adv, issue, accept, wr_en, close;
	logic [AW-1:0]       wr_addr, rd_addr;
	logic [SAMPLE_WIDTH-1:0] rd_data;
	logic signed [FV_W-1:0]  rd_ext;

	kind_t               kind;
	logic [SLOT_W-1:0]   m_off;
	logic                neg, tlast, grp_last, pwr;
	logic [SID_W-1:0]    stream;
	logic [EI_W-1:0]     elem;
	state_t              next_grp;
	logic [SLOT_W:0]     slot_sum;
	logic [SLOT_W-1:0]   rd_slot;
	logic [IDX_W-1:0]    rd_coef;

	logic                v_s1, neg_s1, first_s1, last_s1, lof_s1;
	logic [SID_W-1:0]    stream_s1;
	logic [EI_W-1:0]     elem_s1;
	logic signed [FV_W-1:0] acc_q, term, sum;

	logic                   out_valid_q, out_last_q;
	logic [SID_W-1:0]       out_stream_q;
	logic [EI_W-1:0]        out_elem_q;
	logic signed [FV_W-1:0] out_value_q;

	assign adv    = !out_valid_q || feat.ready;
	assign issue  = (state_q != ST_IDLE) && adv;
	assign accept = coef.valid && coef.ready;
	assign wr_en  = accept && (coef.coef_index <= IDX_W'(CEP_LEN));
	assign close  = accept && (coef.coef_index == IDX_W'(CEP_LEN));

	assign coef.ready = (state_q == ST_IDLE);

	assign wr_addr = AW'(newest_slot_q) * AW'(FL) + AW'(coef.coef_index);

	// Decode the current result group and term into a history offset and sign.
	always_comb begin
		int w;
		w        = SHORT_WIN;
		kind     = K_PLAIN;
		stream   = STREAM_CEP;
		elem     = EI_W'(i_q);
		pwr      = 1'b0;
		grp_last = (i_q == IDX_W'(CEP_LEN - 1));
		next_grp = ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				grp_last = 1'b0;
			end
			ST_CEP: begin
				next_grp = ST_DSH;
			end
			ST_DSH: begin
				kind     = K_DELTA;
				stream   = STREAM_DELTA;
				next_grp = ST_DLG;
			end
			ST_DLG: begin
				kind     = K_DELTA;
				w        = LONG_WIN;
				stream   = STREAM_DELTA;
				elem     = EI_W'(CEP_LEN) + EI_W'(i_q);
				next_grp = ST_PW0;
			end
			ST_PW0: begin
				stream   = STREAM_PWR;
				elem     = EI_W'(0);
				pwr      = 1'b1;
				grp_last = 1'b1;
				next_grp = ST_PW1;
			end
			ST_PW1: begin
				kind     = K_DELTA;
				stream   = STREAM_PWR;
				elem     = EI_W'(1);
				pwr      = 1'b1;
				grp_last = 1'b1;
				next_grp = ST_PW2;
			end
			ST_PW2: begin
				kind     = K_DD;
				stream   = STREAM_PWR;
				elem     = EI_W'(2);
				pwr      = 1'b1;
				grp_last = 1'b1;
				next_grp = ST_DD;
			end
			ST_DD: begin
				kind     = K_DD;
				stream   = STREAM_DD;
				next_grp = ST_IDLE;
			end
			default: begin
				grp_last = 1'b0;
			end
		endcase

		// Offsets count from the oldest frame, so the centre frame is LONG_WIN.
		m_off = SLOT_W'(LONG_WIN);
		neg   = 1'b0;
		tlast = 1'b1;
		case (kind)
			K_DELTA: begin
				tlast = t_q[0];
				neg   = t_q[0];
				m_off = t_q[0] ? SLOT_W'(LONG_WIN - w) : SLOT_W'(LONG_WIN + w);
			end
			K_DD: begin
				tlast = (t_q == 2'd3);
				case (t_q)
					2'd0: begin
						m_off = SLOT_W'(LONG_WIN + SHORT_WIN + 1);
						neg   = 1'b0;
					end
					2'd1: begin
						m_off = SLOT_W'(LONG_WIN - SHORT_WIN + 1);
						neg   = 1'b1;
					end
					2'd2: begin
						m_off = SLOT_W'(LONG_WIN + SHORT_WIN - 1);
						neg   = 1'b1;
					end
					default: begin
						m_off = SLOT_W'(LONG_WIN - SHORT_WIN - 1);
						neg   = 1'b0;
					end
				endcase
			end
			default: begin
				tlast = 1'b1;
			end
		endcase
	end

	// After a close, newest_slot_q already points past the closed frame, which
	// makes it the slot of the oldest frame in the window.
	assign slot_sum = {1'b0, newest_slot_q} + (SLOT_W + 1)'(m_off);
	assign rd_slot  = (slot_sum >= (SLOT_W + 1)'(HD)) ?
		SLOT_W'(slot_sum - (SLOT_W + 1)'(HD)) : SLOT_W'(slot_sum);
	assign rd_coef  = pwr ? IDX_W'(0) : i_q + IDX_W'(1);
	assign rd_addr  = AW'(rd_slot) * AW'(FL) + AW'(rd_coef);

	cdfs_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(DEPTH)
	) u_hist_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(coef.coef_value),
		.re   (issue),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Results wrap modulo 2^FV_W, so wider samples can simply be truncated.
	if (SAMPLE_WIDTH >= FV_W) begin : g_trunc
		assign rd_ext = rd_data[FV_W-1:0];
	end else begin : g_sext
		assign rd_ext = FV_W'(signed'(rd_data));
	end

	assign term = neg_s1 ? -rd_ext : rd_ext;
	assign sum  = first_s1 ? term : acc_q + term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			i_q           <= '0;
			t_q           <= '0;
			newest_slot_q <= '0;
			frames_held_q <= '0;
		end else begin
			if (close) begin
				newest_slot_q <= (newest_slot_q == SLOT_W'(HD - 1)) ?
					'0 : newest_slot_q + SLOT_W'(1);
				if (frames_held_q != HELD_W'(HD)) begin
					frames_held_q <= frames_held_q + HELD_W'(1);
				end
				if (frames_held_q >= HELD_W'(HD - 1)) begin
					state_q <= ST_CEP;
					i_q     <= '0;
					t_q     <= '0;
				end
			end
			if (issue) begin
				if (tlast) begin
					t_q <= '0;
					if (grp_last) begin
						i_q     <= '0;
						state_q <= next_grp;
					end else begin
						i_q <= i_q + IDX_W'(1);
					end
				end else begin
					t_q <= t_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			out_valid_q <= v_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1    <= neg;
			first_s1  <= (t_q == 2'd0);
			last_s1   <= tlast;
			stream_s1 <= stream;
			elem_s1   <= elem;
			lof_s1    <= (state_q == ST_DD) && grp_last && tlast;
			if (v_s1) begin
				if (last_s1) begin
					out_value_q  <= sum;
					out_stream_q <= stream_s1;
					out_elem_q   <= elem_s1;
					out_last_q   <= lof_s1;
				end else begin
					acc_q <= sum;
				end
			end
		end
	end

	assign feat.valid         = out_valid_q;
	assign feat.stream_id     = out_stream_q;
	assign feat.element_index = out_elem_q;
	assign feat.feature_value = out_value_q;
	assign feat.last_of_frame = out_last_q;

endmodule

/* rtl/cdfs_checker.sv */
// Port-level checker for the cepstral delta feature block, with its bind.
`include "cepstral_delta_feature_streams_core_macros.svh"

module cdfs_checker
	import cdfs_pkg::*;
	#(
	parameter int CEP_LEN = CEP_LEN_DEF,
	parameter int IDX_W   = IDX_W_DEF
	) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   coef_valid,
	input logic                   coef_ready,
	input logic [IDX_W-1:0]       coef_index,
	input logic                   feat_valid,
	input logic                   feat_ready,
	input logic [SID_W-1:0]       feat_stream,
	input logic [EI_W-1:0]        feat_elem,
	input logic signed [FV_W-1:0] feat_value,
	input logic                   feat_last
);

	// A stalled result must stay put until it is taken.
	`CDFS_ASSERT_NXT(a_out_hold, clk, arst_n, feat_valid && !feat_ready, feat_valid && $stable(feat_value) && $stable(feat_stream) && $stable(feat_elem) && $stable(feat_last), "stalled result item changed")

	// The input only closes after a frame-closing item was taken.
	`CDFS_ASSERT_IMP(a_busy_after_close, clk, arst_n, $fell(coef_ready), $past(coef_valid && coef_ready && coef_index == IDX_W'(CEP_LEN)), "input stalled without a closing item")

	// The frame ends on the last delta-delta value.
	`CDFS_ASSERT_IMP(a_last_pos, clk, arst_n, feat_valid && feat_last, feat_stream == STREAM_DD && feat_elem == EI_W'(CEP_LEN - 1), "last_of_frame on the wrong item")

	// The power stream has exactly three elements.
	`CDFS_ASSERT_IMP(a_pwr_elem, clk, arst_n, feat_valid && feat_stream == STREAM_PWR, feat_elem == EI_W'(0) || feat_elem == EI_W'(1) || feat_elem == EI_W'(2), "power element index out of range")

endmodule

bind cepstral_delta_feature_streams_core cdfs_checker #(
	.CEP_LEN(CEP_LEN),
	.IDX_W  (IDX_W)
) u_cdfs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.coef_valid (coef.valid),
	.coef_ready (coef.ready),
	.coef_index (coef.coef_index),
	.feat_valid (feat.valid),
	.feat_ready (feat.ready),
	.feat_stream(feat.stream_id),
	.feat_elem  (feat.element_index),
	.feat_value (feat.feature_value),
	.feat_last  (feat.last_of_frame)
);
